FILE: sv/ccrc_pkg.sv
package ccrc_pkg;

  localparam int CrcW    = 16;
  localparam int ByteW   = 8;
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH_MODE = 2'd0,
    CFG_POLYNOMIAL = 2'd1,
    CFG_INIT_VALUE = 2'd2
  } cfg_index_t;

  localparam logic [CrcW-1:0] MASK_16      = 16'hFFFF;
  localparam logic [CrcW-1:0] MASK_8       = 16'h00FF;
  localparam logic            RST_MODE     = 1'b1;
  localparam logic [CrcW-1:0] RST_POLY     = 16'h8810;
  localparam logic [CrcW-1:0] RST_INIT     = 16'hFFFF;
  localparam logic [CrcW-1:0] RST_CRC      = 16'hFFFF;

  // Control from the input stage to the CRC datapath
  typedef struct packed {
    logic step;
    logic first;
  } crc_ctrl_t;

  function automatic logic [CrcW-1:0] width_mask(input logic mode16);
    return mode16 ? MASK_16 : MASK_8;
  endfunction

  // Shift one byte into the CRC low end, MSB first (shift-register form, no zero bytes appended)
  function automatic logic [CrcW-1:0] crc_byte_update(
    input logic [CrcW-1:0]  crc_in,
    input logic [ByteW-1:0] data,
    input logic             mode16,
    input logic [CrcW-1:0]  poly
  );
    logic [CrcW-1:0] mask;
    logic [CrcW-1:0] pm;
    logic [CrcW-1:0] r;
    logic            was_top;
    mask = width_mask(mode16);
    pm   = poly & mask;
    r    = crc_in & mask;
    for (int i = ByteW - 1; i >= 0; i--) begin
      was_top = mode16 ? r[CrcW-1] : r[ByteW-1];
      r = {r[CrcW-2:0], data[i]} & mask;
      if (was_top) begin
        r = r ^ pm;
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/ccrc_if.sv
interface ccrc_byte_if import ccrc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             first_byte;
  logic             last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface ccrc_crc_if import ccrc_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CrcW-1:0] crc_value;

  modport source (output valid, crc_value, input ready);
  modport sink   (input valid, crc_value, output ready);
endinterface

FILE: sv/configurable_crc8_crc16_engine.sv
// Channel   Dir  Fields                               Transfer
// byte_in   in   data_byte[7:0] first_byte last_byte  valid & ready
// crc_out   out  crc_value[15:0]                      valid & ready
// cfg       in   cfg_index[1:0] cfg_data[15:0]        cfg_we
//
// One byte per cycle while no last byte waits: a byte is registered, then
// its eight-bit CRC update runs combinationally into the CRC register and,
// on a last byte, into the result register.
// Reset loads 16-bit mode, polynomial 0x8810, init 0xFFFF, CRC all ones.
// A last byte waits in the input stage only while the result register is
// full and not taken; other bytes never stall.
module configurable_crc8_crc16_engine import ccrc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CrcW-1:0]    cfg_data,
  ccrc_byte_if.sink          byte_in,
  ccrc_crc_if.source         crc_out
);

  logic             width_mode;
  logic [CrcW-1:0]  polynomial;
  logic [CrcW-1:0]  init_value;

  logic             s1_valid;
  logic [ByteW-1:0] s1_data;
  logic             s1_first;
  logic             s1_last;
  logic             s1_fire;

  logic             out_valid;
  logic [CrcW-1:0]  out_crc;
  logic             out_free;

  crc_ctrl_t        ctrl;
  logic [CrcW-1:0]  crc_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode <= RST_MODE;
      polynomial <= RST_POLY;
      init_value <= RST_INIT;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_WIDTH_MODE: width_mode <= cfg_data[0];
        CFG_POLYNOMIAL: polynomial <= cfg_data;
        CFG_INIT_VALUE: init_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage handshakes
  assign out_free      = !out_valid || crc_out.ready;
  assign s1_fire       = s1_valid && (!s1_last || out_free);
  assign byte_in.ready = !s1_valid || s1_fire;

  // Input stage: hold the byte until processed
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      s1_data  <= byte_in.data_byte;
      s1_first <= byte_in.first_byte;
      s1_last  <= byte_in.last_byte;
    end
  end

  // CRC datapath
  assign ctrl.step  = s1_fire;
  assign ctrl.first = s1_first;

  ccrc_update u_update (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .data       (s1_data),
    .width_mode (width_mode),
    .polynomial (polynomial),
    .init_value (init_value),
    .crc_next   (crc_next)
  );

  // Result register: load on a processed last byte, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (crc_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_crc <= crc_next;
    end
  end

  assign crc_out.valid     = out_valid;
  assign crc_out.crc_value = out_crc;

`ifndef SYNTH
  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && out_valid && !crc_out.ready |=> s1_valid && s1_last)
    else $error("last byte left input stage while result blocked");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(s1_valid && s1_last))
    else $error("result appeared without a last byte");

  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && crc_out.ready && !(s1_valid && s1_last) |=> !out_valid)
    else $error("taken result was not dropped");

  a_crc8_upper_zero: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last && !width_mode |=> out_crc[CrcW-1:ByteW] == '0)
    else $error("8-bit result has nonzero upper byte");
`endif

endmodule

FILE: sv/ccrc_update.sv
module ccrc_update import ccrc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  crc_ctrl_t        ctrl,
  input  logic [ByteW-1:0] data,
  input  logic             width_mode,
  input  logic [CrcW-1:0]  polynomial,
  input  logic [CrcW-1:0]  init_value,
  output logic [CrcW-1:0]  crc_next
);

  logic [CrcW-1:0] crc;
  logic [CrcW-1:0] crc_start;

  // Pick the start value: init on a first byte, else the running CRC
  assign crc_start = ctrl.first ? (init_value & width_mask(width_mode)) : crc;
  assign crc_next  = crc_byte_update(crc_start, data, width_mode, polynomial);

  // Advance the running CRC once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= RST_CRC;
    end else if (ctrl.step) begin
      crc <= crc_next;
    end
  end

endmodule

FILE: test/configurable_crc8_crc16_engine_tb.sv
module configurable_crc8_crc16_engine_tb import ccrc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_PHASES  = 14;
  localparam int PHASE_BYTES  = 100;

  // One row of the directed stimulus: a register write or a byte transfer
  typedef struct {
    logic            is_cfg;
    cfg_index_t      idx;
    logic [CrcW-1:0] value;
    logic [7:0]      data;
    logic            first;
    logic            last;
    logic            typed;
    logic [CrcW-1:0] typed_crc;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CrcW-1:0]    cfg_data;

  ccrc_byte_if byte_if();
  ccrc_crc_if  crc_if();

  configurable_crc8_crc16_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_in   (byte_if),
    .crc_out   (crc_if)
  );

  // Predicted engine state and configuration
  logic            crc_wide;
  logic [CrcW-1:0] crc_poly;
  logic [CrcW-1:0] crc_init;
  logic [CrcW-1:0] running_crc;

  logic [CrcW-1:0] crc_expect_q[$];
  stim_row_t       directed_rows[$];

  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int sink_stall_pct;

  always #10 clk = ~clk;

  // Shift one byte into the CRC, MSB first, no augmentation
  function automatic logic [CrcW-1:0] crc_after_byte(logic [CrcW-1:0] crc, logic [7:0] d,
                                                     logic wide, logic [CrcW-1:0] poly);
    logic [CrcW-1:0] mask;
    logic            msb;
    mask = wide ? MASK_16 : MASK_8;
    crc  = crc & mask;
    for (int b = 7; b >= 0; b--) begin
      msb = wide ? crc[15] : crc[7];
      crc = {crc[14:0], d[b]} & mask;
      if (msb) begin
        crc = crc ^ (poly & mask);
      end
    end
    return crc;
  endfunction

  function automatic void row_byte(logic [7:0] d, logic f, logic l);
    stim_row_t r;
    r = '{1'b0, CFG_WIDTH_MODE, '0, d, f, l, 1'b0, '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void row_typed(logic [7:0] d, logic f, logic l, logic [CrcW-1:0] crc);
    stim_row_t r;
    r = '{1'b0, CFG_WIDTH_MODE, '0, d, f, l, 1'b1, crc};
    directed_rows.push_back(r);
  endfunction

  function automatic void row_cfg(cfg_index_t idx, logic [CrcW-1:0] val);
    stim_row_t r;
    r = '{1'b1, idx, val, '0, 1'b0, 1'b0, 1'b0, '0};
    directed_rows.push_back(r);
  endfunction

  // Half the time extremes or well-known polynomials, otherwise random
  function automatic logic [CrcW-1:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h1021;
      3: return 16'h00C6;
      default: return CrcW'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Write one register once the engine has gone quiet
  task automatic write_reg(cfg_index_t idx, logic [CrcW-1:0] val);
    byte_if.valid <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WIDTH_MODE: crc_wide = val[0];
      CFG_POLYNOMIAL: crc_poly = val;
      CFG_INIT_VALUE: crc_init = val;
      default: ;
    endcase
  endtask

  // Offer one byte, hold it until the transfer, then predict its result
  task automatic send_byte(logic [7:0] d, logic f, logic l, logic typed,
                           logic [CrcW-1:0] typed_crc);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_if.valid      <= 1'b0;
      byte_if.data_byte  <= 8'($urandom_range(255));
      byte_if.first_byte <= 1'($urandom_range(1));
      byte_if.last_byte  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    byte_if.valid      <= 1'b1;
    byte_if.data_byte  <= d;
    byte_if.first_byte <= f;
    byte_if.last_byte  <= l;
    do @(posedge clk); while (!byte_if.ready);
    if (f) begin
      running_crc = crc_init & (crc_wide ? MASK_16 : MASK_8);
    end
    running_crc = crc_after_byte(running_crc, d, crc_wide, crc_poly);
    if (l) begin
      crc_expect_q.push_back(typed ? typed_crc : running_crc);
    end
  endtask

  // Drive result back-pressure
  always @(posedge clk) begin
    crc_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    logic [CrcW-1:0] want;
    if (!rst && crc_if.valid && crc_if.ready) begin
      if (crc_expect_q.size() == 0) begin
        $display("%0t: unexpected crc_value %04h, expected none", $time, crc_if.crc_value);
        mismatch_count++;
      end else begin
        want = crc_expect_q.pop_front();
        if (crc_if.crc_value !== want) begin
          $display("%0t: crc_value expected %04h, actual %04h", $time, want,
                   crc_if.crc_value);
          mismatch_count++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    stim_row_t r;
    int        items;
    int        msg_len;
    int        pos;
    logic      in_msg;
    logic      f;
    logic      l;

    clk                = 1'b0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = CFG_WIDTH_MODE;
    cfg_data           = '0;
    byte_if.valid      = 1'b0;
    byte_if.data_byte  = '0;
    byte_if.first_byte = 1'b0;
    byte_if.last_byte  = 1'b0;
    crc_if.ready       = 1'b0;
    mismatch_count     = 0;
    cycle_count        = 0;
    send_idle_pct      = 20;
    sink_stall_pct     = 20;
    crc_wide           = RST_MODE;
    crc_poly           = RST_POLY;
    crc_init           = RST_INIT;
    running_crc        = RST_CRC;

    // Reset-state byte with no first flag, then default-config messages
    row_byte(8'h00, 1'b0, 1'b1);
    row_byte(8'hFF, 1'b1, 1'b1);
    row_byte(8'h00, 1'b1, 1'b0);
    row_byte(8'h80, 1'b0, 1'b0);
    row_byte(8'h01, 1'b0, 1'b1);
    // Zero polynomial: the register is a plain shifter
    row_cfg(CFG_POLYNOMIAL, 16'h0000);
    row_cfg(CFG_INIT_VALUE, 16'h0000);
    row_typed(8'hAB, 1'b1, 1'b1, 16'h00AB);
    row_cfg(CFG_INIT_VALUE, 16'hFFFF);
    row_typed(8'h00, 1'b1, 1'b1, 16'hFF00);
    row_cfg(CFG_WIDTH_MODE, 16'h0000);
    row_typed(8'h00, 1'b1, 1'b1, 16'h0000);
    row_typed(8'h5A, 1'b1, 1'b1, 16'h005A);
    // All-ones polynomial in 8-bit mode
    row_cfg(CFG_POLYNOMIAL, 16'hFFFF);
    row_byte(8'hFF, 1'b1, 1'b1);
    row_byte(8'h00, 1'b0, 1'b1);
    // Mode switch 8 to 16 inside a message
    row_cfg(CFG_POLYNOMIAL, 16'h00C6);
    row_cfg(CFG_INIT_VALUE, 16'h1234);
    row_byte(8'h31, 1'b1, 1'b0);
    row_cfg(CFG_WIDTH_MODE, 16'h0001);
    row_byte(8'h32, 1'b0, 1'b1);
    // Mode switch 16 to 8 inside a message
    row_byte(8'h41, 1'b1, 1'b0);
    row_cfg(CFG_WIDTH_MODE, 16'h0000);
    row_byte(8'h42, 1'b0, 1'b1);
    // First flag in the middle of a running message
    row_cfg(CFG_WIDTH_MODE, 16'h0001);
    row_cfg(CFG_POLYNOMIAL, 16'h8810);
    row_byte(8'hFF, 1'b0, 1'b0);
    row_byte(8'hFF, 1'b1, 1'b1);
    row_byte(8'h7E, 1'b1, 1'b0);
    row_byte(8'hC3, 1'b0, 1'b1);

    // Hold reset, release on a clock edge
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.is_cfg) begin
        write_reg(r.idx, r.value);
      end else begin
        send_byte(r.data, r.first, r.last, r.typed, r.typed_crc);
      end
    end

    // Random phases: new settings, then mostly well-formed messages
    in_msg  = 1'b0;
    msg_len = 1;
    pos     = 0;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      write_reg(CFG_WIDTH_MODE, CrcW'($urandom_range(1)));
      write_reg(CFG_POLYNOMIAL, pick_word());
      write_reg(CFG_INIT_VALUE, pick_word());
      if (phase >= 5 && phase <= 7) begin
        send_idle_pct  = 0;
        sink_stall_pct = 0;
      end else begin
        send_idle_pct  = 20;
        sink_stall_pct = 20;
      end
      items = 0;
      while (items < PHASE_BYTES) begin
        if (!in_msg) begin
          msg_len = ($urandom_range(9) == 0) ? $urandom_range(32, 1) : $urandom_range(6, 1);
          pos     = 0;
          in_msg  = 1'b1;
        end
        f = (pos == 0);
        l = (pos == msg_len - 1);
        // Corrupt the framing now and then
        if ($urandom_range(9) == 0) begin
          f = 1'($urandom_range(1));
          l = 1'($urandom_range(1));
        end
        send_byte(8'($urandom_range(255)), f, l, 1'b0, '0);
        pos++;
        if (pos == msg_len) begin
          in_msg = 1'b0;
        end
        items++;
      end
    end

    // Let the last results out
    byte_if.valid <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ccrc_pkg.sv
sv/ccrc_if.sv
sv/ccrc_update.sv
sv/configurable_crc8_crc16_engine.sv
test/configurable_crc8_crc16_engine_tb.sv
